// ===== rtl/ps2_dec_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2_dec_pkg
// Byte codes, sequence positions and event types for the set-2 decoder.
// ----------------------------------------------------------------------------
package ps2_dec_pkg;

  localparam logic [7:0] BYTE_PAUSE_START = 8'hE1;
  localparam logic [7:0] BYTE_EXTENDED    = 8'hE0;
  localparam logic [7:0] BYTE_RELEASE     = 8'hF0;
  localparam logic [7:0] BYTE_PRTSC_A     = 8'h12;
  localparam logic [7:0] BYTE_PRTSC_B     = 8'h7C;
  localparam logic [7:0] BYTE_PAUSE_END   = 8'h77;

  localparam int unsigned PosW = 4;

  localparam logic [PosW-1:0] POS_IDLE          = 4'd0;
  localparam logic [PosW-1:0] POS_PAUSE_FIRST   = 4'd1;
  localparam logic [PosW-1:0] POS_PRTSC_MAKE    = 4'd2;
  localparam logic [PosW-1:0] POS_PRTSC_BREAK   = 4'd3;
  localparam logic [PosW-1:0] POS_PRTSC_MAKE_END  = 4'd4;
  localparam logic [PosW-1:0] POS_PRTSC_BREAK_END = 4'd6;
  localparam logic [PosW-1:0] POS_PAUSE_END     = 4'd8;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_PRTSC = 2'd1,
    KIND_PAUSE = 2'd2
  } key_kind_e;

  typedef struct packed {
    logic      released;
    logic      extended;
    logic [7:0] code;
    key_kind_e kind;
    logic      last;
  } key_event_t;

endpackage

// ===== rtl/ps2_set2_scan_code_decoder.sv =====
// ----------------------------------------------------------------------------
// ps2_set2_scan_code_decoder
// Decodes PS/2 set-2 scan bytes into key events, tracking E0/F0 prefixes and
// the print-screen and pause sequences.
// ----------------------------------------------------------------------------
// output: an event appears in the cycle after its byte is accepted
// throughput: one byte per cycle while the output is not stalled; after the pause end
//   byte the input stalls while its press and release leave one after the other through the result register
// reset: prefixes, sequence counter and result register are cleared at once
module ps2_set2_scan_code_decoder
  import ps2_dec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       key_released_o,
  output logic       extended_key_o,
  output logic [7:0] scan_code_o,
  output logic [1:0] key_kind_o,
  output logic       last_event_o
);

  logic            ext_q, ext_d;
  logic            rel_q, rel_d;
  logic            seq_q, seq_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic       out_valid_q, out_valid_d;
  key_event_t out_q, out_d;
  logic       pend_q, pend_d;   // pause release waits behind the press

  logic       out_free;
  logic       accept;
  logic [PosW-1:0] pos_inc;
  logic       emit_one;
  logic       emit_two;
  key_event_t ev0;
  key_event_t pause_break;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign pos_inc    = pos_q + 1'b1;

  assign pause_break = '{released: 1'b1, extended: 1'b0, code: 8'h00,
                         kind: KIND_PAUSE, last: 1'b1};

  // decode of one byte against the current prefix and sequence state
  always_comb begin
    ext_d    = ext_q;
    rel_d    = rel_q;
    seq_d    = seq_q;
    pos_d    = pos_q;
    emit_one = 1'b0;
    emit_two = 1'b0;
    ev0      = '{released: 1'b0, extended: 1'b0, code: 8'h00,
                 kind: KIND_KEY, last: 1'b1};
    if (seq_q) begin
      pos_d = pos_inc;
      if (pos_inc == POS_PAUSE_END) begin
        pos_d = POS_IDLE;
        seq_d = 1'b0;
        if (scan_byte_i == BYTE_PAUSE_END) begin
          emit_two = 1'b1;
          ev0.kind = KIND_PAUSE;
          ev0.last = 1'b0;
        end
      end else if (pos_inc == POS_PRTSC_BREAK_END && scan_byte_i == BYTE_PRTSC_A) begin
        pos_d        = POS_IDLE;
        seq_d        = 1'b0;
        ext_d        = 1'b0;
        rel_d        = 1'b0;
        emit_one     = 1'b1;
        ev0.kind     = KIND_PRTSC;
        ev0.released = 1'b1;
      end else if (pos_inc == POS_PRTSC_MAKE_END && scan_byte_i == BYTE_PRTSC_B) begin
        pos_d    = POS_IDLE;
        seq_d    = 1'b0;
        ext_d    = 1'b0;
        emit_one = 1'b1;
        ev0.kind = KIND_PRTSC;
      end
    end else if (scan_byte_i == BYTE_PAUSE_START) begin
      seq_d = 1'b1;
      pos_d = POS_PAUSE_FIRST;
    end else if (scan_byte_i == BYTE_EXTENDED) begin
      ext_d = 1'b1;
    end else if (scan_byte_i == BYTE_RELEASE) begin
      rel_d = 1'b1;
    end else if (scan_byte_i == BYTE_PRTSC_A && ext_q) begin
      seq_d = 1'b1;
      pos_d = POS_PRTSC_MAKE;
    end else if (scan_byte_i == BYTE_PRTSC_B && ext_q && rel_q) begin
      seq_d = 1'b1;
      pos_d = POS_PRTSC_BREAK;
    end else begin
      emit_one     = 1'b1;
      ev0.released = rel_q;
      ev0.extended = ext_q;
      ev0.code     = scan_byte_i;
      ext_d        = 1'b0;
      rel_d        = 1'b0;
    end
  end

  // result register and the queued second event
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pend_d      = pend_q;
    if (pend_q && out_free) begin
      out_valid_d = 1'b1;
      out_d       = pause_break;
      pend_d      = 1'b0;
    end else if (accept) begin
      out_valid_d = emit_one || emit_two;
      out_d       = ev0;
      pend_d      = emit_two;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q       <= 1'b0;
      rel_q       <= 1'b0;
      seq_q       <= 1'b0;
      pos_q       <= POS_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      pend_q      <= 1'b0;
    end else begin
      if (accept) begin
        ext_q <= ext_d;
        rel_q <= rel_d;
        seq_q <= seq_d;
        pos_q <= pos_d;
      end
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      pend_q      <= pend_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_released_o = out_q.released;
  assign extended_key_o = out_q.extended;
  assign scan_code_o    = out_q.code;
  assign key_kind_o     = out_q.kind;
  assign last_event_o   = out_q.last;

endmodule

// ===== rtl/ps2_dec_checker.sv =====
// ----------------------------------------------------------------------------
// ps2_dec_checker
// Port-level checks on the set-2 decoder result stream.
// ----------------------------------------------------------------------------
module ps2_dec_checker
  import ps2_dec_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       key_released_o,
  input logic       extended_key_o,
  input logic [7:0] scan_code_o,
  input logic [1:0] key_kind_o,
  input logic       last_event_o
);

  logic pause_press_taken;
  logic special_kind;

  assign pause_press_taken = out_valid_o && !out_stall_i && key_kind_o == KIND_PAUSE &&
                             !key_released_o;
  assign special_kind = key_kind_o == KIND_PRTSC || key_kind_o == KIND_PAUSE;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_released_o) &&
    $stable(extended_key_o) && $stable(scan_code_o) && $stable(key_kind_o) &&
    $stable(last_event_o))
    else $error("stalled result changed");

  a_special_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && special_kind |-> scan_code_o == 8'h00 && !extended_key_o)
    else $error("special key carries a code or extended flag");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_kind_o != 2'd3)
    else $error("undefined key kind");

  // pause press is never the last event and its release follows at once
  a_pause_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_kind_o == KIND_PAUSE |-> last_event_o == key_released_o)
    else $error("pause event has wrong last flag");

  a_pause_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pause_press_taken |=> out_valid_o && key_kind_o == KIND_PAUSE && key_released_o &&
    last_event_o)
    else $error("pause release did not follow the press");

endmodule

bind ps2_set2_scan_code_decoder ps2_dec_checker u_ps2_dec_checker (.*);
